>>> src/tte_pkg.sv
// Package for the tap tempo estimator: field widths, reset values,
// register and state codes, and the channel payload structs. No dependencies.
`timescale 1ns / 1ps

package tte_pkg;

  // Field widths of the channels.
  localparam int TAP_W        = 32;
  localparam int TEMPO_W      = 16;
  localparam int TAPS_HELD_W  = 4;
  localparam int VALID_IV_W   = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // Default window depth in taps (legal range 2 to 8).
  localparam int WINDOW_TAPS_DEF = 8;

  // Sixty seconds in microseconds times one hundred, for hundredths of a BPM.
  localparam int          NUMER_W             = 33;
  localparam logic [32:0] CENTI_BPM_NUMERATOR = 33'd6000000000;

  // Reset values.
  localparam logic [TEMPO_W-1:0] HELD_TEMPO_RST   = 16'd12000;
  localparam logic [TAP_W-1:0]   GAP_LIMIT_RST    = 32'd2000000;
  localparam logic [TAP_W-1:0]   MIN_INTERVAL_RST = 32'd100000;
  localparam logic [TAP_W-1:0]   MAX_INTERVAL_RST = 32'd2000000;
  localparam logic [TEMPO_W-1:0] TEMPO_FLOOR_RST  = 16'd2000;
  localparam logic [TEMPO_W-1:0] TEMPO_CEIL_RST   = 16'd30000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_LIMIT    = 3'd0,
    CFG_MIN_INTERVAL = 3'd1,
    CFG_MAX_INTERVAL = 3'd2,
    CFG_TEMPO_FLOOR  = 3'd3,
    CFG_TEMPO_CEIL   = 3'd4
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } tte_state_t;

  typedef struct packed {
    logic [TAP_W-1:0] tap_time_us;
  } in_item_t;

  typedef struct packed {
    logic                   tempo_updated;
    logic [TEMPO_W-1:0]     tempo_centi_bpm;
    logic [TAPS_HELD_W-1:0] taps_held;
    logic [VALID_IV_W-1:0]  valid_intervals;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  // Current register contents.
  typedef struct packed {
    logic [TAP_W-1:0]   gap_limit_us;
    logic [TAP_W-1:0]   min_interval_us;
    logic [TAP_W-1:0]   max_interval_us;
    logic [TEMPO_W-1:0] tempo_floor_centi;
    logic [TEMPO_W-1:0] tempo_ceiling_centi;
  } cfg_t;

  // Sequencer commands to the interval line.
  typedef struct packed {
    logic start;  // clear accumulator and scan index
    logic push;   // shift a new interval in
    logic scan;   // rotate one place and accumulate the head
  } line_ctrl_t;

endpackage

>>> src/tte_chan_if.sv
// Valid/ready channel interface with a typed payload.
// Used for the tap, result and configuration channels; no dependencies.
`timescale 1ns / 1ps

interface tte_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/tap_tempo_estimator_unit.sv
// Top level of the tap tempo estimator: sequencer, window bookkeeping and
// tempo clamp. Depends on tte_pkg, tte_chan_if, tte_cfg_regs,
// tte_interval_line and tte_divider.
//
// Usage: each transfer on in_ch is one tap with a free-running microsecond
// timestamp. Every tap yields exactly one result on out_ch: whether a new
// tempo was computed, the held tempo in hundredths of a BPM, the number of
// taps in the window and the number of intervals that were averaged.
// Registers are written on cfg_ch (index, data) and are always accepted;
// write them only while no tap is in flight.
// Sequence: after the accept edge the interval line is scanned, then a load
// state starts the restoring divider, which takes one quotient bit per cycle
// (33 + clog2(WINDOW_TAPS) bits) and then raises its done flag. The divider
// is skipped when no interval counts. in_ch is ready only in idle, so a new
// tap is taken only after the result of the last one has transferred; the
// divider bit loop is the longest part of that wait. A stalled receiver holds
// the result and keeps in_ch not ready.
// Reset (synchronous, active low) empties the window, restores the register
// defaults and sets the held tempo to 120.00 BPM.
`timescale 1ns / 1ps

module tap_tempo_estimator_unit
  import tte_pkg::*;
#(
  parameter int WINDOW_TAPS = WINDOW_TAPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tte_chan_if.sink   in_ch,
  tte_chan_if.source out_ch,
  tte_chan_if.sink   cfg_ch
);

  localparam int CNT_W  = $clog2(WINDOW_TAPS);
  localparam int FILL_W = $clog2(WINDOW_TAPS + 1);
  localparam int SUM_W  = TAP_W + CNT_W;
  localparam int NUM_W  = NUMER_W + CNT_W;

  cfg_t             cfg;
  tte_state_t       state_r, state_nxt;
  line_ctrl_t       line_ctrl;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] quotient;
  logic [NUM_W-1:0] dividend;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;
  logic             scan_last;

  logic [FILL_W-1:0]  fill_r, fill_nxt, fill_base;
  logic [TAP_W-1:0]   prev_r;
  logic               seen_r;
  logic [TEMPO_W-1:0] held_tempo_r, tempo_clamped;
  logic               updated_r;
  logic [TAP_W-1:0]   gap;
  logic               clear_win;
  logic               in_xfer;
  logic [CNT_W-1:0]   held_iv;

  tte_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Window bookkeeping for the incoming tap.
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign gap       = in_ch.payload.tap_time_us - prev_r;
  assign clear_win = !seen_r || (gap > cfg.gap_limit_us);
  assign fill_base = clear_win ? '0 : fill_r;
  assign fill_nxt  = (fill_base >= FILL_W'(WINDOW_TAPS)) ? FILL_W'(WINDOW_TAPS)
                                                         : fill_base + FILL_W'(1);
  assign held_iv   = CNT_W'(fill_r - FILL_W'(1));

  tte_interval_line #(
    .WINDOW_TAPS (WINDOW_TAPS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_line (
    .clk       (clk),
    .ctrl      (line_ctrl),
    .new_iv    (gap),
    .held      (held_iv),
    .min_iv    (cfg.min_interval_us),
    .max_iv    (cfg.max_interval_us),
    .sum       (sum),
    .cnt       (cnt),
    .scan_last (scan_last)
  );

  // Scaled count; the divider registers it at start.
  assign dividend = NUM_W'(CENTI_BPM_NUMERATOR) * NUM_W'(cnt);

  tte_divider #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (sum),
    .done     (div_done),
    .quotient (quotient)
  );

  // Clamp: the floor is tested first, then the ceiling.
  always_comb begin
    if (quotient < NUM_W'(cfg.tempo_floor_centi)) begin
      tempo_clamped = cfg.tempo_floor_centi;
    end else if (quotient > NUM_W'(cfg.tempo_ceiling_centi)) begin
      tempo_clamped = cfg.tempo_ceiling_centi;
    end else begin
      tempo_clamped = quotient[TEMPO_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (scan_last) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = (cnt == '0) ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready     = 1'b0;
    out_ch.valid    = 1'b0;
    line_ctrl       = '0;
    div_start       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready     = 1'b1;
        line_ctrl.start = in_ch.valid;
        line_ctrl.push  = in_ch.valid && (fill_base != '0);
      end
      ST_SUM: begin
        line_ctrl.scan = 1'b1;
      end
      ST_LOAD: begin
        div_start = (cnt != '0);
      end
      ST_DIV: begin
      end
      ST_OUT: begin
        out_ch.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control and window state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      prev_r       <= '0;
      seen_r       <= 1'b0;
      held_tempo_r <= HELD_TEMPO_RST;
      updated_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        fill_r    <= fill_nxt;
        prev_r    <= in_ch.payload.tap_time_us;
        seen_r    <= 1'b1;
        updated_r <= 1'b0;
      end
      if (state_r == ST_DIV && div_done) begin
        held_tempo_r <= tempo_clamped;
        updated_r    <= 1'b1;
      end
    end
  end

  // Result payload comes straight from registers.
  assign out_ch.payload.tempo_updated   = updated_r;
  assign out_ch.payload.tempo_centi_bpm = held_tempo_r;
  assign out_ch.payload.taps_held       = TAPS_HELD_W'(fill_r);
  assign out_ch.payload.valid_intervals = updated_r ? VALID_IV_W'(cnt) : '0;

endmodule

>>> src/tte_cfg_regs.sv
// Configuration register file of the tap tempo estimator.
// Depends on tte_pkg and tte_chan_if.
`timescale 1ns / 1ps

module tte_cfg_regs
  import tte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tte_chan_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t cfg_r, cfg_nxt;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.payload.reg_index))
        CFG_GAP_LIMIT:    cfg_nxt.gap_limit_us        = cfg_ch.payload.data;
        CFG_MIN_INTERVAL: cfg_nxt.min_interval_us     = cfg_ch.payload.data;
        CFG_MAX_INTERVAL: cfg_nxt.max_interval_us     = cfg_ch.payload.data;
        CFG_TEMPO_FLOOR:  cfg_nxt.tempo_floor_centi   = cfg_ch.payload.data[TEMPO_W-1:0];
        CFG_TEMPO_CEIL:   cfg_nxt.tempo_ceiling_centi = cfg_ch.payload.data[TEMPO_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_limit_us        <= GAP_LIMIT_RST;
      cfg_r.min_interval_us     <= MIN_INTERVAL_RST;
      cfg_r.max_interval_us     <= MAX_INTERVAL_RST;
      cfg_r.tempo_floor_centi   <= TEMPO_FLOOR_RST;
      cfg_r.tempo_ceiling_centi <= TEMPO_CEIL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/tte_interval_line.sv
// Shift line of tap intervals with a rotating scan that sums the in-bounds ones.
// Depends on tte_pkg.
`timescale 1ns / 1ps

module tte_interval_line
  import tte_pkg::*;
#(
  parameter int WINDOW_TAPS = WINDOW_TAPS_DEF,
  parameter int CNT_W       = $clog2(WINDOW_TAPS),
  parameter int SUM_W       = TAP_W + CNT_W
) (
  input  logic             clk,
  input  line_ctrl_t       ctrl,
  input  logic [TAP_W-1:0] new_iv,
  input  logic [CNT_W-1:0] held,
  input  logic [TAP_W-1:0] min_iv,
  input  logic [TAP_W-1:0] max_iv,
  output logic [SUM_W-1:0] sum,
  output logic [CNT_W-1:0] cnt,
  output logic             scan_last
);

  localparam int            DEPTH    = WINDOW_TAPS - 1;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(WINDOW_TAPS - 2);

  // Newest interval sits at entry 0. Contents need no reset: only the
  // entries below the held count are ever summed.
  logic [TAP_W-1:0] line_r [DEPTH];
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;
  logic             take;

  // The head holds original entry idx_r after idx_r rotations.
  assign take = (idx_r < held) && (line_r[0] > min_iv) && (line_r[0] < max_iv);
  assign scan_last = (idx_r == LAST_IDX);

  // Storage: push shifts toward the old end, scan rotates toward the head.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      line_r[0] <= new_iv;
      for (int j = 1; j < DEPTH; j++) begin
        line_r[j] <= line_r[j-1];
      end
    end else if (ctrl.scan) begin
      line_r[DEPTH-1] <= line_r[0];
      for (int j = 0; j < DEPTH - 1; j++) begin
        line_r[j] <= line_r[j+1];
      end
    end
  end

  // Accumulator with the shared add and bounds compare.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sum_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
    end else if (ctrl.scan) begin
      if (take) begin
        sum_r <= sum_r + SUM_W'(line_r[0]);
        cnt_r <= cnt_r + CNT_W'(1);
      end
      idx_r <= idx_r + CNT_W'(1);
    end
  end

  assign sum = sum_r;
  assign cnt = cnt_r;

endmodule

>>> src/tte_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tte_pkg.
`timescale 1ns / 1ps

module tte_divider
  import tte_pkg::*;
#(
  parameter int NUM_W = NUMER_W + 3,
  parameter int DEN_W = TAP_W + 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  dvd_r;    // dividend bits shift out, quotient bits in
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] steps_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // Shift in the next dividend bit and try one subtract.
  assign trial = {rem_r, dvd_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      steps_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        steps_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        steps_r <= steps_r - STEP_W'(1);
        if (steps_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[NUM_W-2:0], fits};
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

>>> tb/tap_tempo_estimator_unit_tb.sv
// Testbench for tap_tempo_estimator_unit: drives taps and register writes and
// checks every result against a scoreboard that predicts the tempo per tap.
// Depends on tte_pkg, tte_chan_if and the tap_tempo_estimator_unit RTL.
`timescale 1ns / 1ps

module tap_tempo_estimator_unit_tb
  import tte_pkg::*;
;

  localparam int CLK_HALF_NS   = 10;
  localparam int RST_CYCLES    = 4;
  localparam int DRAIN_SLACK   = 50;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_TAPS    = 250;
  localparam int HOLD_CYCLES   = 400;
  localparam int N_DIRECTED    = 19;
  localparam int MAX_REPORTS   = 10;
  localparam int CFG_SPARE_IDX = CFG_TEMPO_CEIL + 1;

  // Scoreboard: keeps its own window and registers and queues the result
  // expected for each accepted tap.
  class tempo_scoreboard;
    logic [TAP_W-1:0] window [WINDOW_TAPS_DEF];
    int unsigned      fill;
    logic [TAP_W-1:0] prev_tap;
    bit               have_tap;
    logic [TEMPO_W-1:0] held_tempo;
    cfg_t             regs;
    out_item_t        expected [$];
    int unsigned      errors;
    int unsigned      results;

    function new();
      fill       = 0;
      prev_tap   = '0;
      have_tap   = 0;
      held_tempo = HELD_TEMPO_RST;
      regs.gap_limit_us        = GAP_LIMIT_RST;
      regs.min_interval_us     = MIN_INTERVAL_RST;
      regs.max_interval_us     = MAX_INTERVAL_RST;
      regs.tempo_floor_centi   = TEMPO_FLOOR_RST;
      regs.tempo_ceiling_centi = TEMPO_CEIL_RST;
      errors  = 0;
      results = 0;
    endfunction

    // Register write; indexes beyond the last register are ignored.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAP_LIMIT:    regs.gap_limit_us = data;
        CFG_MIN_INTERVAL: regs.min_interval_us = data;
        CFG_MAX_INTERVAL: regs.max_interval_us = data;
        CFG_TEMPO_FLOOR:  regs.tempo_floor_centi = data[TEMPO_W-1:0];
        CFG_TEMPO_CEIL:   regs.tempo_ceiling_centi = data[TEMPO_W-1:0];
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted tap.
    function void note_tap(logic [TAP_W-1:0] now);
      logic [TAP_W-1:0] gap;
      logic [TAP_W-1:0] iv;
      logic [63:0]      iv_sum;
      logic [63:0]      tempo;
      int unsigned      iv_count;
      out_item_t        want;
      gap = now - prev_tap;
      if (!have_tap || gap > regs.gap_limit_us) fill = 0;
      have_tap = 1;
      prev_tap = now;
      // A full window drops its oldest tap.
      if (fill >= WINDOW_TAPS_DEF) begin
        for (int i = 1; i < WINDOW_TAPS_DEF; i++) window[i-1] = window[i];
        fill = WINDOW_TAPS_DEF - 1;
      end
      window[fill] = now;
      fill++;
      iv_sum   = '0;
      iv_count = 0;
      for (int i = 1; i < fill; i++) begin
        iv = window[i] - window[i-1];
        if (iv > regs.min_interval_us && iv < regs.max_interval_us) begin
          iv_sum = iv_sum + 64'(iv);
          iv_count++;
        end
      end
      want.tempo_updated = 1'b0;
      if (iv_count > 0) begin
        tempo = (64'(CENTI_BPM_NUMERATOR) * 64'(iv_count)) / iv_sum;
        // The floor is tested first, so it wins when it lies above the ceiling.
        if (tempo < 64'(regs.tempo_floor_centi)) tempo = 64'(regs.tempo_floor_centi);
        else if (tempo > 64'(regs.tempo_ceiling_centi)) tempo = 64'(regs.tempo_ceiling_centi);
        held_tempo = tempo[TEMPO_W-1:0];
        want.tempo_updated = 1'b1;
      end
      want.tempo_centi_bpm = held_tempo;
      want.taps_held       = fill[TAPS_HELD_W-1:0];
      want.valid_intervals = want.tempo_updated ? iv_count[VALID_IV_W-1:0] : '0;
      expected = {expected, want};
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    function void report_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    // Compare one result transfer with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      results++;
      if (expected.size() == 0) begin
        report_error($sformatf("result %0d with no tap waiting: upd=%0d tempo=%0d taps=%0d iv=%0d",
                               results, got.tempo_updated, got.tempo_centi_bpm,
                               got.taps_held, got.valid_intervals));
        return;
      end
      want = expected.pop_front();
      if (got !== want)
        report_error($sformatf({"result %0d: expected upd=%0d tempo=%0d taps=%0d iv=%0d, ",
                                "got upd=%0d tempo=%0d taps=%0d iv=%0d"}, results,
                               want.tempo_updated, want.tempo_centi_bpm, want.taps_held,
                               want.valid_intervals, got.tempo_updated,
                               got.tempo_centi_bpm, got.taps_held, got.valid_intervals));
    endfunction

    // Expectations still queued at the end are failures.
    function void close();
      if (expected.size() != 0)
        report_error($sformatf("%0d taps never produced a result", expected.size()));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tte_chan_if #(.payload_t(in_item_t))   in_ch ();
  tte_chan_if #(.payload_t(out_item_t))  out_ch ();
  tte_chan_if #(.payload_t(cfg_write_t)) cfg_ch ();

  tap_tempo_estimator_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tempo_scoreboard sb = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_left;
  logic [TAP_W-1:0] directed_taps [N_DIRECTED];

  // Clock.
  initial clk = 1'b0;
  always #(CLK_HALF_NS) clk = ~clk;

  // Known values on every input from time zero.
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_left   = 0;
  end

  // Result receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every result transfer is checked.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
  end

  // Offer one tap after a random gap and wait for its transfer.
  task automatic send_tap(input logic [TAP_W-1:0] tap);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= tap;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tap(tap);
  endtask

  // Stop offering taps and wait until every expected result has arrived.
  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // One register write; valid stays high so writes can run back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.payload.reg_index <= idx;
    cfg_ch.payload.data      <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
  endtask

  // Write the whole register set while the block is idle. The 16-bit
  // registers get random upper bits, and the unused indexes random data.
  task automatic apply_settings(input logic [TAP_W-1:0] gap_lim, input logic [TAP_W-1:0] min_iv,
                                input logic [TAP_W-1:0] max_iv, input logic [TEMPO_W-1:0] floor_c,
                                input logic [TEMPO_W-1:0] ceil_c);
    wait_drain();
    write_reg(CFG_GAP_LIMIT, gap_lim);
    write_reg(CFG_MIN_INTERVAL, min_iv);
    write_reg(CFG_MAX_INTERVAL, max_iv);
    write_reg(CFG_TEMPO_FLOOR, {16'($urandom()), floor_c});
    write_reg(CFG_TEMPO_CEIL, {16'($urandom()), ceil_c});
    for (int i = CFG_SPARE_IDX; i < (1 << CFG_IDX_W); i++)
      write_reg(i[CFG_IDX_W-1:0], $urandom());
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stimulus.
  initial begin
    logic [TAP_W-1:0] tap;
    logic [TAP_W-1:0] session_iv;
    int unsigned      pick;

    // Directed taps under the reset settings: first tap, interval equal to the
    // minimum, gap equal to the limit, gap above the limit, a window that
    // overflows with a tempo above the ceiling, and timestamp wrap.
    directed_taps = '{32'd0, 32'd500000, 32'd1000000, 32'd1100000, 32'd3099999,
                      32'd5099999, 32'd7100000, 32'd7250000, 32'd7400000, 32'd7550000,
                      32'd7700000, 32'd7850000, 32'd8000000, 32'd8150000, 32'd8300000,
                      32'hFFFE_795F, 32'hFFFF_FFFF, 32'h0007_A11F, 32'h0007_A11F};

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 17;
    rx_idle_pct = 73;
    foreach (directed_taps[i]) send_tap(directed_taps[i]);

    tap        = 32'd0;
    session_iv = 32'd500000;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_settings(GAP_LIMIT_RST, MIN_INTERVAL_RST, MAX_INTERVAL_RST,
                          TEMPO_FLOOR_RST, TEMPO_CEIL_RST);
        1: apply_settings(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
        2: apply_settings(32'd3000000, 32'd150000, 32'd2500000, 16'd20000, 16'd8000);
        3: apply_settings(32'd0, 32'hFFFF_FFFF, 32'd0, 16'd100, 16'd200);
        4: apply_settings(32'd2500000, 32'd200000, 32'd1500000, 16'd4000, 16'd24000);
        default: apply_settings(32'd500000, 32'd1000, 32'd400000, 16'd100, 16'hFFFF);
      endcase
      // Idling: sender light and receiver heavy, then swapped, then none.
      case (p / 2)
        0: begin tx_idle_pct = 17; rx_idle_pct = 73; end
        1: begin tx_idle_pct = 73; rx_idle_pct = 17; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase

      for (int k = 0; k < PHASE_TAPS; k++) begin
        // Long receiver hold-off while taps keep coming.
        if (p == 1 && k == 50) rx_hold_left = HOLD_CYCLES;
        // Sender waits for every result before going on.
        if (k == PHASE_TAPS / 2) wait_drain();
        // Mostly steady tapping sessions with jitter, plus short taps, long
        // pauses, random timestamps and runs that cross the wrap.
        if (k % 12 == 0) session_iv = $urandom_range(1000, 2600000);
        pick = $urandom_range(99);
        if (pick < 70)      tap = tap + session_iv + $urandom_range(0, 30000);
        else if (pick < 78) tap = tap + $urandom_range(0, 200000);
        else if (pick < 86) tap = tap + $urandom_range(2000000, 12000000);
        else if (pick < 94) tap = $urandom();
        else                tap = 32'hFFFF_FFFF - $urandom_range(0, 3000000);
        send_tap(tap);
      end
    end

    wait_drain();
    sb.close();
    if (sb.errors == 0) begin
      $display("[tap_tempo_estimator_unit] OK");
    end else begin
      $display("[tap_tempo_estimator_unit] ERROR");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #20_000_000;
    $display("[tap_tempo_estimator_unit] ERROR");
    $finish;
  end

endmodule
